@@ sv/tdmd_pkg.sv @@
// Shared widths, reset values and register indexes of the motion detector.
`default_nettype none
package tdmd_pkg;

  localparam int PIX_W              = 8;
  localparam int MARGIN_W           = 8;
  localparam int FRAME_W            = 17;
  localparam int CFG_W              = 17;
  localparam int CFG_IDX_W          = 1;
  localparam int TDATA_W            = 8;
  localparam int HISTORY_FRAMES_DEF = 16;
  localparam int MAX_PIXELS_DEF     = 65536;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd30;
  localparam logic [FRAME_W-1:0]  FRAME_RESET  = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARGIN       = 1'b0,
    REG_FRAME_PIXELS = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

@@ sv/temporal_deviation_motion_detector.sv @@
// Top level of the temporal deviation motion detector.
// Accepts one grey pixel per clock in raster order and returns one flag per pixel through
// stage 1, stage 2 and the output register, at one pixel per cycle unless output stalls. The
// rate is set by the history RAM, which takes one read at acceptance and one write of the
// updated history word as the pixel leaves stage 1; a pixel that reads the word still being
// written takes it from a forwarding register. The history RAM has no clearing pass: the
// first frame after reset writes every position with the current sample and raises no flags;
// results from positions never written (frame length raised after the first frame) are
// undefined. Configuration writes take effect at once and are meant for idle periods only.
`default_nettype none
module temporal_deviation_motion_detector
  import tdmd_pkg::*;
#(
  parameter int HISTORY_FRAMES = HISTORY_FRAMES_DEF,
  parameter int MAX_PIXELS     = MAX_PIXELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [TDATA_W-1:0]   s_axis_tdata,   // [7:0] pixel_value
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [TDATA_W-1:0]   m_axis_tdata,   // [0] motion_flag, [7:1] zero
  output logic                      m_axis_tlast,   // end_of_frame
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int Stored = HISTORY_FRAMES - 1;
  localparam int MemW   = Stored * PIX_W;
  localparam int PosW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CntW   = $clog2(MAX_PIXELS + 1);
  localparam int LenW   = (CntW > FRAME_W) ? CntW : FRAME_W;

  logic [MARGIN_W-1:0] margin;
  logic [FRAME_W-1:0]  frame_pixels;
  logic [PosW-1:0]     pos;
  logic                primed;

  logic [LenW-1:0] len_m1;
  logic            in_last;
  logic            accept;
  logic            en2;
  logic            en_out;

  logic             s1_valid;
  logic [PIX_W-1:0] s1_cur;
  logic [PosW-1:0]  s1_pos;
  logic             s1_last;
  logic             s1_primed;
  logic             s1_fwd;
  logic [MemW-1:0]  fwd_data;
  logic [MemW-1:0]  ram_rdata;
  logic [MemW-1:0]  old_hist;
  logic [MemW-1:0]  new_hist;
  logic             ram_we;
  logic [HISTORY_FRAMES-1:0][PIX_W-1:0] s1_values;
  logic [PIX_W-1:0] s1_mean;

  logic             s2_valid;
  logic [PIX_W-1:0] s2_cur;
  logic [MemW-1:0]  s2_hist;
  logic [PIX_W-1:0] s2_mean;
  logic             s2_last;
  logic             s2_primed;
  logic [HISTORY_FRAMES-1:0][PIX_W-1:0] s2_dev;
  logic [PIX_W-1:0] dmean;
  logic [PIX_W-1:0] dcur;
  logic [PIX_W-1:0] excess;
  logic             flag;

  logic out_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin       <= MARGIN_RESET;
      frame_pixels <= FRAME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MARGIN:       margin       <= cfg_wdata[MARGIN_W-1:0];
        REG_FRAME_PIXELS: frame_pixels <= cfg_wdata[FRAME_W-1:0];
        default:          margin       <= margin;
      endcase
    end
  end

  always_comb begin
    if (frame_pixels == '0) begin
      len_m1 = '0;
    end else if (LenW'(frame_pixels) > LenW'(MAX_PIXELS)) begin
      len_m1 = LenW'(MAX_PIXELS - 1);
    end else begin
      len_m1 = LenW'(frame_pixels) - LenW'(1);
    end
  end

  assign in_last       = (LenW'(pos) >= len_m1);
  assign en_out        = !m_axis_tvalid || m_axis_tready;
  assign en2           = !s2_valid || en_out;
  assign s_axis_tready = !s1_valid || en2;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      primed <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        pos    <= '0;
        primed <= 1'b1;
      end else begin
        pos <= pos + PosW'(1);
      end
    end
  end

  // Stage 1: history word arrives, mean of all samples, history update.
  assign old_hist = s1_fwd ? fwd_data : ram_rdata;
  assign new_hist = s1_primed ?
                    ((old_hist >> PIX_W) | (MemW'(s1_cur) << (MemW - PIX_W))) :
                    {Stored{s1_cur}};
  assign ram_we   = s1_valid && en2;

  always_comb begin
    s1_values[0] = s1_cur;
    for (int i = 0; i < Stored; i++) begin
      s1_values[i+1] = old_hist[i*PIX_W +: PIX_W];
    end
  end

  tdmd_mean #(.COUNT(HISTORY_FRAMES)) u_mean (
    .values (s1_values),
    .mean   (s1_mean)
  );

  tdmd_ram #(.WIDTH(MemW), .DEPTH(MAX_PIXELS)) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_pos),
    .wdata (new_hist),
    .re    (accept),
    .raddr (pos),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
      s1_fwd   <= s_axis_tvalid && s1_valid && (s1_pos == pos);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cur    <= s_axis_tdata[PIX_W-1:0];
      s1_pos    <= pos;
      s1_last   <= in_last;
      s1_primed <= primed;
      fwd_data  <= new_hist;
    end
  end

  // Stage 2: deviations from the mean and their mean, threshold test.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      s2_cur    <= s1_cur;
      s2_hist   <= old_hist;
      s2_mean   <= s1_mean;
      s2_last   <= s1_last;
      s2_primed <= s1_primed;
    end
  end

  assign dcur = (s2_cur > s2_mean) ? (s2_cur - s2_mean) : (s2_mean - s2_cur);

  always_comb begin
    s2_dev[0] = dcur;
    for (int i = 0; i < Stored; i++) begin
      s2_dev[i+1] = (s2_hist[i*PIX_W +: PIX_W] > s2_mean) ?
                    (s2_hist[i*PIX_W +: PIX_W] - s2_mean) :
                    (s2_mean - s2_hist[i*PIX_W +: PIX_W]);
    end
  end

  tdmd_mean #(.COUNT(HISTORY_FRAMES)) u_dev_mean (
    .values (s2_dev),
    .mean   (dmean)
  );

  assign excess = dcur - dmean;
  assign flag   = s2_primed && (dcur > dmean) && (excess > margin);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en_out) begin
      m_axis_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && s2_valid) begin
      out_flag     <= flag;
      m_axis_tlast <= s2_last;
    end
  end

  assign m_axis_tdata = {{(TDATA_W-1){1'b0}}, out_flag};

`ifndef SYNTH
  a_wrap_on_last: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> pos == '0)
    else $error("position did not wrap after the last pixel of a frame");

  a_primed_holds: assert property (@(posedge clk) disable iff (rst)
    primed |=> primed)
    else $error("primed flag dropped");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (rst)
    s1_fwd |-> s1_valid)
    else $error("forwarded history without an item in stage 1");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    !s2_valid && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared without an item in stage 2");

  a_stall_no_accept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !en2 |-> !s_axis_tready)
    else $error("request taken while stage 1 is stalled");
`endif

endmodule
`default_nettype wire

@@ sv/tdmd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tdmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ sv/tdmd_mean.sv @@
// Truncated mean of a fixed count of 8-bit samples, division by reciprocal.
`default_nettype none
module tdmd_mean
  import tdmd_pkg::*;
#(
  parameter int COUNT = HISTORY_FRAMES_DEF
) (
  input  wire logic [COUNT-1:0][PIX_W-1:0] values,
  output logic      [PIX_W-1:0]            mean
);

  localparam int LogC   = $clog2(COUNT);
  localparam int SumW   = PIX_W + LogC;
  localparam int Shift  = SumW + LogC;
  localparam int RecipW = Shift + 1;
  localparam int ProdW  = SumW + RecipW;
  localparam int Recip  = ((1 << Shift) + COUNT - 1) / COUNT;

  logic [SumW-1:0]  sum;
  logic [ProdW-1:0] prod;

  always_comb begin
    sum = '0;
    for (int i = 0; i < COUNT; i++) begin
      sum = sum + SumW'(values[i]);
    end
  end

  assign prod = ProdW'(sum) * ProdW'(Recip);
  assign mean = prod[Shift +: PIX_W];

endmodule
`default_nettype wire
